// ----- design/cocktail_shaker_sort_macros.svh -----
// ----------------------------------------------------------------------------
// Cocktail shaker sort assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef COCKTAIL_SHAKER_SORT_MACROS_SVH
`define COCKTAIL_SHAKER_SORT_MACROS_SVH

// same-cycle implication
`define CKS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CKS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/cks_pkg.sv -----
// ----------------------------------------------------------------------------
// Cocktail shaker sort package
// Sizes, entry and request types, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package cks_pkg;

  localparam int MAX_MEMBERS = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int IDX_W       = $clog2(MAX_MEMBERS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int POS_W       = 6;

  typedef struct packed {
    logic signed [KEY_WIDTH-1:0] key;
    logic [IDX_W-1:0]            pos;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic   valid;
    entry_t item;
    logic   last;
  } push_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_FWD_FIRST,
    S_FWD_LOAD,
    S_FWD_STEP,
    S_FWD_END,
    S_BWD_STEP,
    S_BWD_END,
    S_EMIT_READ,
    S_EMIT_PUSH
  } state_t;

endpackage

`default_nettype wire

// ----- design/cks_mem.sv -----
// ----------------------------------------------------------------------------
// Entry store
// One write port, one registered read port, holds key and load position.
// ----------------------------------------------------------------------------
`default_nettype none

module cks_mem (
  input  wire logic              clk,
  input  wire cks_pkg::mem_req_t req,
  output cks_pkg::entry_t        rd_data
);
  import cks_pkg::*;

  entry_t mem [MAX_MEMBERS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- design/cks_seq.sv -----
// ----------------------------------------------------------------------------
// Shaker sequencer
// Loads entries, runs forward/backward passes through one comparator with a
// carried entry, then reads the sorted entries out.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cocktail_shaker_sort_macros.svh"

module cks_seq (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [cks_pkg::KEY_WIDTH-1:0]   in_key,
  input  wire logic                            in_last,
  input  wire cks_pkg::entry_t                 rd_data,
  output cks_pkg::mem_req_t                    req,
  input  wire logic                            out_free,
  output cks_pkg::push_t                       push
);
  import cks_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] idx, idx_next;
  entry_t           hold, hold_next;
  logic             swap_seen, swap_next;

  logic [IDX_W-1:0] last_idx;
  logic             accept, set_end, key_lt;
  entry_t           cmp_lo, cmp_hi;

  assign last_idx = IDX_W'(count - CNT_W'(1));
  assign accept   = in_valid && in_ready;
  assign set_end  = in_last || (count == CNT_W'(MAX_MEMBERS - 1));

  // shared compare: forward asks right < carried, backward carried < left
  always_comb begin
    if (state == S_BWD_STEP) begin
      cmp_lo = hold;
      cmp_hi = rd_data;
    end else begin
      cmp_lo = rd_data;
      cmp_hi = hold;
    end
  end
  assign key_lt = $signed(cmp_lo.key) < $signed(cmp_hi.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      idx       <= '0;
      swap_seen <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      idx       <= idx_next;
      swap_seen <= swap_next;
    end
  end

  always_ff @(posedge clk) begin
    hold <= hold_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (accept && set_end) begin
          state_next = (count == '0) ? S_EMIT_READ : S_FWD_FIRST;
        end
      end
      S_FWD_FIRST: state_next = S_FWD_LOAD;
      S_FWD_LOAD:  state_next = S_FWD_STEP;
      S_FWD_STEP: begin
        if (idx == last_idx) begin
          state_next = S_FWD_END;
        end
      end
      S_FWD_END:   state_next = swap_seen ? S_BWD_STEP : S_EMIT_READ;
      S_BWD_STEP: begin
        if (idx == '0) begin
          state_next = S_BWD_END;
        end
      end
      S_BWD_END:   state_next = S_FWD_STEP;
      S_EMIT_READ: state_next = S_EMIT_PUSH;
      S_EMIT_PUSH: begin
        if (out_free && (idx == last_idx)) begin
          state_next = S_LOAD;
        end
      end
      default:     state_next = S_LOAD;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    req         = '0;
    req.wr_data = hold;
    push        = '0;
    count_next  = count;
    idx_next    = idx;
    hold_next   = hold;
    swap_next   = swap_seen;
    case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        if (accept) begin
          req.wr_en       = 1'b1;
          req.wr_addr     = count[IDX_W-1:0];
          req.wr_data.key = in_key;
          req.wr_data.pos = count[IDX_W-1:0];
          count_next      = count + CNT_W'(1);
          idx_next        = '0;
        end
      end
      S_FWD_FIRST: begin
        req.rd_en   = 1'b1;
        req.rd_addr = '0;
        swap_next   = 1'b0;
      end
      S_FWD_LOAD: begin
        hold_next   = rd_data;
        req.rd_en   = 1'b1;
        req.rd_addr = IDX_W'(1);
        idx_next    = IDX_W'(1);
      end
      S_FWD_STEP: begin
        // carried entry drifts right while it is the larger one
        req.wr_en   = 1'b1;
        req.wr_addr = idx - IDX_W'(1);
        if (key_lt) begin
          req.wr_data = rd_data;
          swap_next   = 1'b1;
        end else begin
          req.wr_data = hold;
          hold_next   = rd_data;
        end
        if (idx != last_idx) begin
          req.rd_en   = 1'b1;
          req.rd_addr = idx + IDX_W'(1);
          idx_next    = idx + IDX_W'(1);
        end
      end
      S_FWD_END: begin
        // carried entry is the largest: write it to the top slot; if the pass swapped, start backward pass with it
        req.wr_en   = 1'b1;
        req.wr_addr = last_idx;
        req.wr_data = hold;
        if (swap_seen) begin
          req.rd_en   = 1'b1;
          req.rd_addr = last_idx - IDX_W'(1);
          idx_next    = last_idx - IDX_W'(1);
        end else begin
          idx_next = '0;
        end
      end
      S_BWD_STEP: begin
        req.wr_en   = 1'b1;
        req.wr_addr = idx + IDX_W'(1);
        if (key_lt) begin
          req.wr_data = rd_data;
          swap_next   = 1'b1;
        end else begin
          req.wr_data = hold;
          hold_next   = rd_data;
        end
        if (idx != '0) begin
          req.rd_en   = 1'b1;
          req.rd_addr = idx - IDX_W'(1);
          idx_next    = idx - IDX_W'(1);
        end
      end
      S_BWD_END: begin
        req.wr_en   = 1'b1;
        req.wr_addr = '0;
        req.wr_data = hold;
        req.rd_en   = 1'b1;
        req.rd_addr = IDX_W'(1);
        idx_next    = IDX_W'(1);
        swap_next   = 1'b0;
      end
      S_EMIT_READ: begin
        req.rd_en   = 1'b1;
        req.rd_addr = idx;
      end
      S_EMIT_PUSH: begin
        if (out_free) begin
          push.valid = 1'b1;
          push.item  = rd_data;
          push.last  = (idx == last_idx);
          if (idx == last_idx) begin
            count_next = '0;
          end else begin
            req.rd_en   = 1'b1;
            req.rd_addr = idx + IDX_W'(1);
            idx_next    = idx + IDX_W'(1);
          end
        end
      end
      default: begin
        count_next = '0;
      end
    endcase
  end

  `CKS_ASSERT_IMPLY(a_no_rw_collide, req.wr_en && req.rd_en, req.wr_addr != req.rd_addr, "read and write hit the same entry")
  `CKS_ASSERT_IMPLY(a_idx_in_set, state != S_LOAD, idx < count, "index outside loaded set")
  `CKS_ASSERT_IMPLY(a_sort_has_pair, (state == S_FWD_STEP) || (state == S_BWD_STEP), count >= CNT_W'(2), "pass run on fewer than two entries")
  `CKS_ASSERT_NEXT(a_run_done, push.valid && push.last, (state == S_LOAD) && (count == '0), "loader not rearmed after final result")

endmodule

`default_nettype wire

// ----- design/cocktail_shaker_sort.sv -----
// Flow: after the tlast (or 64th) transaction, sets of n > 1 entries run forward
//   and backward passes until a forward pass swaps nothing, then are read out
//   while m_tready allows; one entry skips sorting.
// Throughput: one input item per cycle while loading; each pass walks one entry
//   per cycle through the shared comparator; no input is taken until readout ends.
// Reset: rst synchronous, active high; returns to loading with an empty set.
// ----------------------------------------------------------------------------
// Cocktail shaker sort
// Stream sorter: loads keys, shaker-sorts them in place, streams them out
// in ascending order with their load positions.
// ----------------------------------------------------------------------------
`default_nettype none

module cocktail_shaker_sort (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [cks_pkg::KEY_WIDTH-1:0] s_tdata,   // [31:0] merit_key
  input  wire logic                          s_tlast,   // last_in
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [39:0]                        m_tdata,   // [31:0] sorted_key,
                                                        // [37:32] source_position
  output logic                               m_tlast    // last_out
);
  import cks_pkg::*;

  mem_req_t req;
  entry_t   rd_data;
  push_t    push;
  logic     out_free;

  logic     out_valid;
  entry_t   out_item;
  logic     out_last;

  cks_mem u_mem (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  cks_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_key   (s_tdata),
    .in_last  (s_tlast),
    .rd_data  (rd_data),
    .req      (req),
    .out_free (out_free),
    .push     (push)
  );

  // output register; refilled in the same cycle it drains
  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push.valid) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      out_item <= push.item;
      out_last <= push.last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, POS_W'(out_item.pos), 32'(out_item.key)};
  assign m_tlast  = out_last;

endmodule

`default_nettype wire

// ----- test/cocktail_shaker_sort_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cocktail shaker sort checker
// Watches both stream channels. It keeps its own copy of the loaded set and
// orders each finished set the way the sorter should. It then checks every
// output transaction against the oldest outstanding result.
// ----------------------------------------------------------------------------

module cocktail_shaker_sort_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [cks_pkg::KEY_WIDTH-1:0] s_tdata,   // [31:0] merit_key
  input  logic                          s_tlast,   // last_in
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [39:0]                   m_tdata,   // [31:0] sorted_key, [37:32] source_position
  input  logic                          m_tlast,   // last_out
  output int                            mismatches,
  output int                            pending,
  output int                            sets_done,
  output int                            results_done
);
  import cks_pkg::*;

  typedef struct packed {
    logic signed [KEY_WIDTH-1:0] key;
    logic [POS_W-1:0]            pos;
    logic                        last;
  } ranked_member_t;

  ranked_member_t              ranking_q[$];
  logic signed [KEY_WIDTH-1:0] member_key [MAX_MEMBERS];
  logic [POS_W-1:0]            member_pos [MAX_MEMBERS];
  int                          member_count;
  int                          mismatch_total;
  int                          sets_total;
  int                          results_total;

  function automatic void swap_members(input int a, input int b);
    logic signed [KEY_WIDTH-1:0] k;
    logic [POS_W-1:0]            p;
    k = member_key[a];
    p = member_pos[a];
    member_key[a] = member_key[b];
    member_pos[a] = member_pos[b];
    member_key[b] = k;
    member_pos[b] = p;
  endfunction

  // Forward pass, stop if it moved nothing, then backward pass; strict
  // compares keep equal keys in load order.
  function automatic void shaker_order(input int n);
    logic moved;
    if (n <= 1) return;
    while (1'b1) begin
      moved = 1'b0;
      for (int i = 0; i + 1 < n; i++) begin
        if (member_key[i+1] < member_key[i]) begin
          swap_members(i, i + 1);
          moved = 1'b1;
        end
      end
      if (!moved) break;
      for (int i = n - 1; i > 0; i--) begin
        if (member_key[i] < member_key[i-1]) begin
          swap_members(i, i - 1);
        end
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    ranked_member_t want;
    if (rst) begin
      ranking_q.delete();
      member_count   = 0;
      mismatch_total = 0;
      sets_total     = 0;
      results_total  = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        member_key[member_count] = s_tdata;
        member_pos[member_count] = member_count[POS_W-1:0];
        member_count++;
        // a full store closes the set whether or not tlast is set
        if (s_tlast || member_count == MAX_MEMBERS) begin
          shaker_order(member_count);
          for (int k = 0; k < member_count; k++) begin
            want.key  = member_key[k];
            want.pos  = member_pos[k];
            want.last = (k == member_count - 1);
            ranking_q.insert(ranking_q.size(), want);
          end
          member_count = 0;
        end
      end

      if (m_tvalid && m_tready) begin
        results_total++;
        if (m_tlast) sets_total++;
        if (ranking_q.size() == 0) begin
          $error("unexpected result: sorted_key %0d source_position %0d",
                 $signed(m_tdata[KEY_WIDTH-1:0]), m_tdata[37:32]);
          mismatch_total++;
        end else begin
          want = ranking_q.pop_front();
          if (m_tdata[KEY_WIDTH-1:0] !== want.key) begin
            $error("sorted_key: expected %0d, got %0d", want.key,
                   $signed(m_tdata[KEY_WIDTH-1:0]));
            mismatch_total++;
          end
          if (m_tdata[37:32] !== want.pos) begin
            $error("source_position: expected %0d, got %0d", want.pos, m_tdata[37:32]);
            mismatch_total++;
          end
          if (m_tlast !== want.last) begin
            $error("last_out: expected %0d, got %0d", want.last, m_tlast);
            mismatch_total++;
          end
        end
      end
    end
    mismatches   <= mismatch_total;
    pending      <= ranking_q.size();
    sets_done    <= sets_total;
    results_done <= results_total;
  end

endmodule

// ----- test/cocktail_shaker_sort_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cocktail shaker sort testbench
// Sends key sets: first hand-picked ones (extremes, ties, presorted, reversed,
// single members), then random sets of random sizes and key patterns,
// including full stores with and without tlast. Both stream sides idle at
// random. The output side holds off once for a long stretch. The checker
// predicts and compares; this module only drives and reports.
// ----------------------------------------------------------------------------

module cocktail_shaker_sort_tb;
  import cks_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 1200;
  localparam int SETTLE_CYCLES = 64;
  localparam int ITEM_TARGET   = 360;
  localparam int IDLE_PERCENT  = 9;

  localparam logic signed [KEY_WIDTH-1:0] KEY_MIN = {1'b1, {(KEY_WIDTH-1){1'b0}}};
  localparam logic signed [KEY_WIDTH-1:0] KEY_MAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};

  typedef enum int {
    PAT_RANDOM,
    PAT_CLUSTER,
    PAT_RISING,
    PAT_FALLING,
    PAT_EXTREMES
  } key_pattern_e;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [KEY_WIDTH-1:0] s_tdata  = '0;
  logic                 s_tlast  = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [39:0]          m_tdata;
  logic                 m_tlast;

  int   mismatches;
  int   outstanding;
  int   sets_checked;
  int   results_checked;
  int   cycles       = 0;
  int   items_sent   = 0;
  logic steady       = 1'b0;
  logic hold_request = 1'b0;
  logic hold_taken;
  int   hold_left;

  logic signed [KEY_WIDTH-1:0] set_keys [MAX_MEMBERS];

  cocktail_shaker_sort dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  cocktail_shaker_sort_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .mismatches   (mismatches),
    .pending      (outstanding),
    .sets_done    (sets_checked),
    .results_done (results_checked)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Output side: random back-pressure, plus one long hold-off so the sorter
  // backs up into its input.
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_taken) begin
      m_tready   <= 1'b0;
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
    end else begin
      m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  task automatic send_item(input logic signed [KEY_WIDTH-1:0] key, input logic last);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_set(input int n, input logic mark_final);
    for (int k = 0; k < n; k++) send_item(set_keys[k], (k == n - 1) ? mark_final : 1'b0);
  endtask

  // stop offering, then wait for every expected result
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic fill_set(input int n);
    key_pattern_e                pattern;
    logic signed [KEY_WIDTH-1:0] base;
    pattern = key_pattern_e'($urandom_range(0, 4));
    base    = $urandom;
    for (int k = 0; k < n; k++) begin
      case (pattern)
        PAT_RANDOM:  set_keys[k] = $urandom;
        PAT_CLUSTER: set_keys[k] = KEY_WIDTH'($urandom_range(0, 6)) - 3;
        PAT_RISING:  set_keys[k] = base + k;
        PAT_FALLING: set_keys[k] = base - k;
        default: begin
          case ($urandom_range(0, 4))
            0:       set_keys[k] = KEY_MIN;
            1:       set_keys[k] = KEY_MAX;
            2:       set_keys[k] = '0;
            3:       set_keys[k] = '1;
            default: set_keys[k] = $urandom;
          endcase
        end
      endcase
    end
  endtask

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 1;
    if (r < 75) return $urandom_range(2, 8);
    return $urandom_range(9, 24);
  endfunction

  initial begin
    int set_idx;
    int size;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single members at both key extremes
    set_keys[0] = KEY_MIN;
    send_set(1, 1'b1);
    set_keys[0] = KEY_MAX;
    send_set(1, 1'b1);
    // extremes swapped
    set_keys[0] = KEY_MAX;
    set_keys[1] = KEY_MIN;
    send_set(2, 1'b1);
    // all keys tied: load order must survive
    for (int k = 0; k < 3; k++) set_keys[k] = '1;
    send_set(3, 1'b1);
    // mixed signs with ties
    set_keys[0] = 0;
    set_keys[1] = -1;
    set_keys[2] = 1;
    set_keys[3] = KEY_MIN;
    set_keys[4] = KEY_MAX;
    set_keys[5] = 1;
    set_keys[6] = 0;
    send_set(7, 1'b1);
    // reversed, then already in order (first pass finds nothing to move)
    for (int k = 0; k < 5; k++) set_keys[k] = 5 - k;
    send_set(5, 1'b1);
    set_keys[0] = -5;
    set_keys[1] = 0;
    set_keys[2] = 5;
    send_set(3, 1'b1);
    drain();

    // long output hold-off while the next set is offered
    hold_request <= 1'b1;
    fill_set(8);
    send_set(8, 1'b1);
    fill_set(6);
    send_set(6, 1'b1);
    drain();

    set_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      steady <= (set_idx >= 5 && set_idx < 12);
      // full stores: one closed by the count alone, one also marked tlast
      size = (set_idx == 2 || set_idx == 14) ? MAX_MEMBERS : pick_size();
      fill_set(size);
      send_set(size, (size < MAX_MEMBERS) || (set_idx == 14));
      if (set_idx == 18) drain();
      set_idx++;
    end
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d input items in %0d sets, %0d sorted results checked,",
             items_sent, sets_checked, results_checked);
    $display("sets of 1 to 64 members, tied and extreme keys, long output stall.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/cks_pkg.sv
design/cks_mem.sv
design/cks_seq.sv
design/cocktail_shaker_sort.sv
test/cocktail_shaker_sort_checker.sv
test/cocktail_shaker_sort_tb.sv
